// File: hw/rtl/coq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coq_pkg - circle overlap query shared definitions
// Table size, item formats, controller state and the control/status bundles
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package coq_pkg;

  // table geometry
  localparam int SLOTS      = 64;
  localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FW    = 6;
  localparam int COORD_W    = 24;
  localparam int RAD_W      = 16;
  localparam int ID_W       = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int RSUM_W     = RAD_W + 1;
  localparam int RSQ_W      = 2 * RSUM_W;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // input transaction
  typedef struct packed {
    logic                      mode;
    logic [SLOT_FW-1:0]        slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RAD_W-1:0]          radius;
    logic [ID_W-1:0]           owner_id;
    logic                      present;
  } coq_in_t;

  // result transaction
  typedef struct packed {
    logic               hit;
    logic [SLOT_FW-1:0] hit_slot;
    logic [ID_W-1:0]    hit_owner;
  } coq_out_t;

  // one stored circle
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RAD_W-1:0]          r;
    logic [ID_W-1:0]           owner;
  } coq_entry_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } coq_state_t;

  // controller to datapath
  typedef struct packed {
    logic write;       // store the incoming item into its slot
    logic load_query;  // capture query fields, rewind the scan counter
    logic issue;       // read the next slot into the pipeline
    logic flush;       // drop everything in flight
    logic res_load;    // load the result register
    logic res_hit;     // result comes from the last stage, else all zero
  } coq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;  // scan counter points at the last slot
    logic end_vld;     // last stage holds a slot
    logic end_match;   // that slot overlaps the query
    logic end_last;    // that slot is the last one of the table
  } coq_stat_t;

endpackage

// File: hw/rtl/coq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coq_dp - circle overlap query datapath
// Circle memory with valid bits, scan counter, four-stage distance pipeline
// (read, difference, square, compare) and the result register.
// ---------------------------------------------------------------------------
module coq_dp
  import coq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  coq_in_t   in_data,
  input  coq_cmd_t  cmd,
  output coq_stat_t stat,
  output coq_out_t  out_data
);

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOTS - 1);

  // storage
  coq_entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  // query registers
  logic signed [COORD_W-1:0] qx_r;
  logic signed [COORD_W-1:0] qy_r;
  logic [RAD_W-1:0]          qr_r;
  logic [ID_W-1:0]           qid_r;

  // scan counter
  logic [SLOT_AW-1:0] cnt_r;

  // stage 0: memory read
  coq_entry_t         rd0_r;
  logic               vb0_r;
  logic               v0_r;
  logic               last0_r;
  logic [SLOT_AW-1:0] slot0_r;

  // stage 1: differences
  logic signed [DIFF_W-1:0] dx1_r;
  logic signed [DIFF_W-1:0] dy1_r;
  logic [RSUM_W-1:0]        rs1_r;
  logic                     el1_r;
  logic                     v1_r;
  logic                     last1_r;
  logic [SLOT_AW-1:0]       slot1_r;
  logic [ID_W-1:0]          own1_r;

  // stage 2: squares
  logic [SQ_W-1:0]    sx2_r;
  logic [SQ_W-1:0]    sy2_r;
  logic [RSQ_W-1:0]   sr2_r;
  logic               el2_r;
  logic               v2_r;
  logic               last2_r;
  logic [SLOT_AW-1:0] slot2_r;
  logic [ID_W-1:0]    own2_r;

  // stage 3: compare
  logic               m3_r;
  logic               v3_r;
  logic               last3_r;
  logic [SLOT_AW-1:0] slot3_r;
  logic [ID_W-1:0]    own3_r;

  coq_out_t out_r;

  logic                     wr_ok;
  logic [SLOT_AW-1:0]       wr_addr;
  coq_entry_t               wr_entry;
  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;
  logic [RSUM_W-1:0]        rs_nxt;
  logic signed [2*DIFF_W-1:0] sqx;
  logic signed [2*DIFF_W-1:0] sqy;
  logic [RSQ_W-1:0]         sqr;
  logic [DIST_W-1:0]        dist_sq;
  logic                     m_nxt;

  // write decode, slots beyond the table are dropped
  assign wr_ok    = (32'(in_data.slot) < 32'(SLOTS));
  assign wr_addr  = SLOT_AW'(in_data.slot);
  assign wr_entry = '{x: in_data.pos_x, y: in_data.pos_y,
                      r: in_data.radius, owner: in_data.owner_id};

  // memory write and scan read
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.issue) begin
      rd0_r <= mem[cnt_r];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write && wr_ok) begin
      valid_r[wr_addr] <= in_data.present;
    end
  end

  // query capture and scan counter
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx_r  <= in_data.pos_x;
      qy_r  <= in_data.pos_y;
      qr_r  <= in_data.radius;
      qid_r <= in_data.owner_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_query) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // stage arithmetic
  assign dx_nxt  = DIFF_W'(qx_r) - DIFF_W'(rd0_r.x);
  assign dy_nxt  = DIFF_W'(qy_r) - DIFF_W'(rd0_r.y);
  assign rs_nxt  = RSUM_W'(qr_r) + RSUM_W'(rd0_r.r);
  assign sqx     = dx1_r * dx1_r;
  assign sqy     = dy1_r * dy1_r;
  assign sqr     = RSQ_W'(rs1_r) * RSQ_W'(rs1_r);
  assign dist_sq = DIST_W'(sx2_r) + DIST_W'(sy2_r);
  assign m_nxt   = el2_r && (dist_sq < DIST_W'(sr2_r));

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      vb0_r   <= valid_r[cnt_r];
      last0_r <= (cnt_r == LAST_SLOT);
      slot0_r <= cnt_r;
    end
    dx1_r   <= dx_nxt;
    dy1_r   <= dy_nxt;
    rs1_r   <= rs_nxt;
    el1_r   <= vb0_r && (rd0_r.owner != qid_r);
    last1_r <= last0_r;
    slot1_r <= slot0_r;
    own1_r  <= rd0_r.owner;
    sx2_r   <= sqx[SQ_W-1:0];
    sy2_r   <= sqy[SQ_W-1:0];
    sr2_r   <= sqr;
    el2_r   <= el1_r;
    last2_r <= last1_r;
    slot2_r <= slot1_r;
    own2_r  <= own1_r;
    m3_r    <= m_nxt;
    last3_r <= last2_r;
    slot3_r <= slot2_r;
    own3_r  <= own2_r;
  end

  // pipeline occupancy
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.res_hit) begin
        out_r <= '{hit: 1'b1, hit_slot: SLOT_FW'(slot3_r), hit_owner: own3_r};
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_data        = out_r;
  assign stat.last_issue = (cnt_r == LAST_SLOT);
  assign stat.end_vld    = v3_r;
  assign stat.end_match  = m3_r;
  assign stat.end_last   = last3_r;

endmodule

// File: hw/rtl/coq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coq_ctrl - circle overlap query controller
// Accepts transactions, sequences the slot scan and strobes the result.
// ---------------------------------------------------------------------------
module coq_ctrl
  import coq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_mode,
  input  logic      in_present,
  input  coq_stat_t stat,
  output coq_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  coq_state_t state_r;
  coq_state_t state_nxt;
  logic       issue_done_r;
  logic       issue_done_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;
  logic       finish;

  assign accept = start && (state_r == ST_IDLE);
  assign finish = stat.end_vld && (stat.end_match || stat.end_last);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    issue_done_nxt = issue_done_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.write = (in_mode == MODE_WRITE);
          if (in_mode == MODE_QUERY && in_present) begin
            cmd.load_query = 1'b1;
            issue_done_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.res_load  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (finish) begin
          cmd.res_load  = 1'b1;
          cmd.res_hit   = stat.end_match;
          cmd.flush     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!issue_done_r) begin
          cmd.issue = 1'b1;
          if (stat.last_issue) begin
            issue_done_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == ST_SCAN);
  assign out_valid = out_valid_r;

  // no strobe while a scan is running
  a_no_strobe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_valid_r)
    else $error("result strobe during scan");

  // a body query starts a scan
  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_QUERY && in_present) |=> busy)
    else $error("query did not start a scan");

  // writes and bodiless queries answer in the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_WRITE || !in_present)) |=> (out_valid_r && !busy))
    else $error("missing immediate result");

  // end of scan returns to idle with a strobe
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && finish) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("scan did not finish cleanly");

  // no read is issued after the last slot
  a_no_overissue: assert property (@(posedge clk) disable iff (!rst_n)
    issue_done_r && (state_r == ST_SCAN) |-> !cmd.issue)
    else $error("slot issued past end of table");

endmodule

// File: hw/rtl/circle_overlap_query.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_overlap_query - table of circles with first-overlap search
// Stores up to SLOTS circles and answers overlap queries against them.
// ---------------------------------------------------------------------------
// A write transaction (or a query whose querier has no body) is answered by
// a one-cycle out_valid strobe in the cycle after start; busy stays low, so
// such transactions can follow each other every cycle. A query with a body
// raises busy and walks the table one slot per cycle through the single
// read port of the circle memory, feeding a four-stage pipeline (read,
// difference, square, compare). It ends at the first overlapping slot, or
// after the last slot on a miss, and the result strobes then; busy falls
// together with the strobe. The receiver cannot stall: out_data is valid
// only during the single cycle in which out_valid is high.
module circle_overlap_query
  import coq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  coq_in_t  in_data,
  output logic     out_valid,
  output coq_out_t out_data
);

  coq_cmd_t  cmd;
  coq_stat_t stat;

  // sequencing
  coq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_data.mode),
    .in_present (in_data.present),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // storage and arithmetic
  coq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - circle overlap query regression
// Drives write and query transactions into circle_overlap_query and checks
// every result strobe against a local predictor of the circle table: first
// valid, non-self slot whose squared center distance is strictly below the
// squared radius sum. Directed corner cases come first, then clustered
// random traffic with random sender gaps and a few full drains.
// ---------------------------------------------------------------------------
module tb_top;
  import coq_pkg::*;

  localparam int IDLE_LIMIT  = 1000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES = 80;    // wait after the last result before the final check
  localparam int N_RANDOM    = 1550;
  localparam int CALM_TAIL   = 300;   // last random items go back to back

  typedef struct {
    coq_in_t item;
    int      gap;    // idle cycles before this item
    bit      drain;  // hold until every outstanding result is back
  } stim_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  coq_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  coq_out_t out_data;

  circle_overlap_query i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // predicted circle table
  logic signed [COORD_W-1:0] circ_x     [SLOTS];
  logic signed [COORD_W-1:0] circ_y     [SLOTS];
  logic [RAD_W-1:0]          circ_r     [SLOTS];
  logic [ID_W-1:0]           circ_owner [SLOTS];
  bit                        circ_valid [SLOTS] = '{default: 1'b0};

  // what the stimulus generator has written, used to aim queries
  int  aim_x [SLOTS];
  int  aim_y [SLOTS];
  // owner last written to a slot by the generator, for self skip queries
  logic [ID_W-1:0] aim_owner [SLOTS];

  stim_t    stim_q[$];
  coq_out_t answer_q[$];
  coq_out_t want_res;
  stim_t    next_item;
  bit       in_taken    = 1'b0;
  bit       launch;
  int       gap_left    = -1;
  int       idle_cycles = 0;
  int       n_errors    = 0;
  int       n_total     = 0;
  int       n_accepted  = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // apply one transaction to the predicted table and return its answer
  function automatic coq_out_t answer_item(coq_in_t it);
    coq_out_t res;
    longint   dx;
    longint   dy;
    longint   rsum;
    res = '0;
    if (it.mode == MODE_WRITE) begin
      if (int'(it.slot) < SLOTS) begin
        circ_x[it.slot]     = it.pos_x;
        circ_y[it.slot]     = it.pos_y;
        circ_r[it.slot]     = it.radius;
        circ_owner[it.slot] = it.owner_id;
        circ_valid[it.slot] = it.present;
      end
      return res;
    end
    // querier without a body never hits
    if (!it.present) return res;
    for (int i = 0; i < SLOTS; i++) begin
      if (circ_valid[i] && circ_owner[i] != it.owner_id) begin
        dx   = longint'($signed(it.pos_x)) - longint'($signed(circ_x[i]));
        dy   = longint'($signed(it.pos_y)) - longint'($signed(circ_y[i]));
        rsum = longint'(it.radius) + longint'(circ_r[i]);
        // strict compare: touching circles do not overlap
        if (dx * dx + dy * dy < rsum * rsum) begin
          res.hit       = 1'b1;
          res.hit_slot  = SLOT_FW'(i);
          res.hit_owner = circ_owner[i];
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic coq_in_t make_item(logic mode, int slot, int x, int y, int r,
                                        logic [ID_W-1:0] id, logic pres);
    coq_in_t it;
    it.mode     = mode;
    it.slot     = SLOT_FW'(slot);
    it.pos_x    = COORD_W'(x);
    it.pos_y    = COORD_W'(y);
    it.radius   = RAD_W'(r);
    it.owner_id = id;
    it.present  = pres;
    return it;
  endfunction

  task automatic queue_item(input coq_in_t it, input int gap, input bit drain);
    stim_t s;
    s.item  = it;
    s.gap   = gap;
    s.drain = drain;
    stim_q.push_back(s);
    n_total++;
    if (it.mode == MODE_WRITE) begin
      aim_x[it.slot]     = int'($signed(it.pos_x));
      aim_y[it.slot]     = int'($signed(it.pos_y));
      aim_owner[it.slot] = it.owner_id;
    end
  endtask

  // mostly near a cluster center, sometimes anywhere
  function automatic int rand_coord(int center);
    if ($urandom_range(99) < 15) return int'($urandom());
    return center + int'($urandom_range(8192)) - 4096;
  endfunction

  function automatic int rand_radius();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 30) return int'($urandom_range(65535));
    return int'($urandom_range(2048));
  endfunction

  // small id pool so self skips happen often
  function automatic logic [ID_W-1:0] rand_owner();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    if (pick < 16) return $urandom();
    return ID_W'(32'h10 + $urandom_range(7));
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(99) < 30) return int'($urandom_range(6, 1));
    return 0;
  endfunction

  // driver: next transaction goes out at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      launch = 1'b0;
      if (stim_q.size() != 0) begin
        if (gap_left < 0) gap_left = stim_q[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!stim_q[0].drain || answer_q.size() == 0) begin
          next_item = stim_q.pop_front();
          gap_left  = -1;
          launch    = 1'b1;
        end
      end
      if (launch) in_data <= next_item.item;
      start <= launch;
    end
  end

  // monitor: check results, then predict the transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown");
      end else if (out_valid) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected: hit=%0b slot=%0d owner=%h",
                                    out_data.hit, out_data.hit_slot, out_data.hit_owner));
        end else begin
          want_res = answer_q.pop_front();
          if (out_data.hit !== want_res.hit)
            report_mismatch($sformatf("hit %b, expected %b", out_data.hit, want_res.hit));
          if (out_data.hit_slot !== want_res.hit_slot)
            report_mismatch($sformatf("hit_slot %0d, expected %0d",
                                      out_data.hit_slot, want_res.hit_slot));
          if (out_data.hit_owner !== want_res.hit_owner)
            report_mismatch($sformatf("hit_owner %h, expected %h",
                                      out_data.hit_owner, want_res.hit_owner));
        end
      end
    end
    in_taken = rst_n && start && !busy;
    if (in_taken) begin
      answer_q.push_back(answer_item(in_data));
      n_accepted++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("circle_overlap_query regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    coq_in_t it;
    int      gap;
    int      pick;
    int      s;
    int      cx;
    int      cy;
    bit      drain;
    int      centers [4];

    centers = '{0, 8388607 - 4096, -8388608 + 4096, 100000};

    // fill every slot once, all empty, so no entry is read before written
    for (int i = 0; i < SLOTS; i++)
      queue_item(make_item(MODE_WRITE, i, int'($urandom()), int'($urandom()),
                           int'($urandom_range(65535)), $urandom(), 1'b0), rand_gap(), 1'b0);

    // query on an empty table, after a full drain
    queue_item(make_item(MODE_QUERY, 0, 0, 0, 65535, 32'h1, 1'b1), 0, 1'b1);
    // extreme corners and field extremes
    queue_item(make_item(MODE_WRITE, 0, 8388607, -8388608, 65535, 32'hFFFF_FFFF, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_WRITE, 63, -8388608, 8388607, 0, 32'h0, 1'b1), 0, 1'b0);
    // own id skipped
    queue_item(make_item(MODE_QUERY, 0, 8388607, -8388608, 0, 32'hFFFF_FFFF, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 63, 8388607, -8388608, 0, 32'h1, 1'b1), 0, 1'b0);
    // querier without a body
    queue_item(make_item(MODE_QUERY, 0, 8388607, -8388608, 65535, 32'h1, 1'b0), 0, 1'b0);
    // far corner, widest difference on the way to the last slot
    queue_item(make_item(MODE_QUERY, 5, -8388608, 8388607, 65535, 32'h2, 1'b1), 0, 1'b0);
    // zero radius circles on the same point only touch
    queue_item(make_item(MODE_WRITE, 10, 1000, 1000, 0, 32'h7, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 1000, 1000, 0, 32'h8, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 1000, 1000, 1, 32'h8, 1'b1), 0, 1'b0);
    // 3-4-5 triangle: exact touch, then one step closer
    queue_item(make_item(MODE_WRITE, 11, 0, 0, 2, 32'h9, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 3, 4, 3, 32'h8, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 3, 4, 4, 32'h8, 1'b1), 0, 1'b0);
    // lowest slot wins, self skip falls through to the next one
    queue_item(make_item(MODE_WRITE, 30, 50000, 50000, 256, 32'h30, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_WRITE, 20, 50000, 50000, 256, 32'h20, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 50000, 50000, 0, 32'h99, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 50000, 50000, 0, 32'h20, 1'b1), 0, 1'b0);
    // clearing a slot removes it
    queue_item(make_item(MODE_WRITE, 20, 50000, 50000, 256, 32'h20, 1'b0), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 50000, 50000, 0, 32'h99, 1'b1), 0, 1'b0);
    queue_item(make_item(MODE_WRITE, 0, 8388607, -8388608, 65535, 32'hFFFF_FFFF, 1'b0), 0, 1'b0);
    queue_item(make_item(MODE_QUERY, 0, 8388607, -8388608, 65535, 32'h1, 1'b1), 0, 1'b0);

    // random traffic: clustered writes and queries aimed at stored circles
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k >= N_RANDOM - CALM_TAIL || (k >= 600 && k < 800)) gap = 0;
      else gap = rand_gap();
      drain = (k % 400 == 0);
      pick  = $urandom_range(99);
      if (pick < 8) begin
        it = make_item(logic'($urandom_range(1)), int'($urandom_range(63)),
                       int'($urandom()), int'($urandom()), int'($urandom_range(65535)),
                       $urandom(), logic'($urandom_range(1)));
      end else if (pick < 45) begin
        cx = centers[$urandom_range(3)];
        cy = centers[$urandom_range(3)];
        it = make_item(MODE_WRITE, int'($urandom_range(63)), rand_coord(cx), rand_coord(cy),
                       rand_radius(), rand_owner(), logic'($urandom_range(9) != 0));
      end else begin
        s = $urandom_range(63);
        if ($urandom_range(99) < 75) begin
          cx = aim_x[s] + int'($urandom_range(2048)) - 1024;
          cy = aim_y[s] + int'($urandom_range(2048)) - 1024;
        end else begin
          cx = rand_coord(centers[$urandom_range(3)]);
          cy = rand_coord(centers[$urandom_range(3)]);
        end
        it = make_item(MODE_QUERY, int'($urandom_range(63)), cx, cy, rand_radius(),
                       ($urandom_range(99) < 20) ? aim_owner[s] : rand_owner(),
                       logic'($urandom_range(19) != 0));
      end
      queue_item(it, gap, drain);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || answer_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));

    if (n_errors == 0) begin
      $display("circle_overlap_query regression: pass");
    end else begin
      $display("circle_overlap_query regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/coq_pkg.sv
hw/rtl/coq_dp.sv
hw/rtl/coq_ctrl.sv
hw/rtl/circle_overlap_query.sv
verif/tb_top.sv
